>>> hdl/sdd_pkg.sv
package sdd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_TERM_BYTES_DEF = 32;
  localparam int LENGTH_BITS_DEF    = 16;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int TERM_LEN_W  = 6;
  localparam int TERM_WORDS  = 4;
  localparam int TERM_BYTES  = TERM_WORDS * CFG_DATA_W / 8;

  typedef logic [7:0] byte_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TERM_LENGTH = 3'd0,
    REG_TERM_WORD_A = 3'd1,
    REG_TERM_WORD_B = 3'd2,
    REG_TERM_WORD_C = 3'd3,
    REG_TERM_WORD_D = 3'd4
  } cfg_reg_t;

endpackage

>>> hdl/sdd_in_if.sv
interface sdd_in_if;
  import sdd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> hdl/sdd_out_if.sv
interface sdd_out_if #(
  parameter int LENGTH_BITS = sdd_pkg::LENGTH_BITS_DEF
);
  import sdd_pkg::*;

  logic                   valid;
  logic                   ready;
  byte_t                  payload_byte;
  logic                   has_payload;
  logic                   end_of_message;
  logic [LENGTH_BITS-1:0] message_length;

  modport source (output valid, output payload_byte, output has_payload,
                  output end_of_message, output message_length, input ready);
  modport sink   (input valid, input payload_byte, input has_payload,
                  input end_of_message, input message_length, output ready);
endinterface

>>> hdl/suffix_delimited_deframer_core.sv
// Terminator-delimited message deframer.
// in_ch carries one received byte per transaction; out_ch carries at most one
// result per input byte: a payload byte (has_payload), an end-of-message flag
// and, with end_of_message, the saturated payload count of that message.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the terminator
// length (register 0) and the terminator bytes (registers 1 to 4, 8 bytes
// each, byte i at bits 8i). Writing the length drops a partial message.
// Each message first fills a window as long as the terminator; from then on
// every byte pushes the oldest window byte out as payload. A window equal to
// the terminator ends the message.
// An input transaction passes through the input register, then one compute pass
// into the output register. Throughput: 1 byte per cycle while out_ch takes
// results, set by the one-pass window update and parallel terminator compare.
// A byte that only fills the window gives no result.
// Reset (synchronous, rst_n low): empty window, counts zero, length 1,
// terminator all zeros. When out_ch stalls, the output register holds and the
// input register fills, then in_ch.ready drops until the result is taken.
module suffix_delimited_deframer_core #(
  parameter int MAX_TERMINATOR_BYTES = sdd_pkg::MAX_TERM_BYTES_DEF,
  parameter int LENGTH_BITS          = sdd_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sdd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdd_pkg::CFG_DATA_W-1:0]  cfg_data,
  sdd_in_if.sink                        in_ch,
  sdd_out_if.source                     out_ch
);
  import sdd_pkg::*;

  localparam int DEPTH = MAX_TERMINATOR_BYTES;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Configuration registers
  logic [TERM_LEN_W-1:0]                term_len_r;
  logic [TERM_WORDS-1:0][CFG_DATA_W-1:0] term_word_r;

  // Input stage
  logic  in_valid_r;
  byte_t in_byte_r;

  // Deframer state
  logic [DEPTH-1:0][7:0]  win_r;
  logic [CNT_W-1:0]       fill_r;
  logic [LENGTH_BITS-1:0] pc_r;

  // Output register
  logic                   out_valid_r;
  byte_t                  out_byte_r;
  logic                   out_has_r;
  logic                   out_eom_r;
  logic [LENGTH_BITS-1:0] out_len_r;

  logic                   adv;
  logic                   proc;
  logic [TERM_LEN_W-1:0]  len_clamp;
  logic [CNT_W-1:0]       len_eff;
  logic [CNT_W-1:0]       len_m1;
  logic                   filling;
  logic                   full;
  logic                   match;
  logic                   eom;
  logic [DEPTH-1:0][7:0]  win_fill;
  logic [DEPTH-1:0][7:0]  win_shift;
  logic [DEPTH-1:0][7:0]  win_nxt;
  logic [TERM_WORDS*CFG_DATA_W-1:0] term_flat;
  logic [DEPTH-1:0][7:0]  term_bytes;
  logic [LENGTH_BITS-1:0] pc_inc;
  logic [CNT_W-1:0]       fill_inc;

  // Handshake: the input stage moves on whenever the output register is empty or its result is taken
  assign adv          = !out_valid_r || out_ch.ready;
  assign proc         = in_valid_r && adv;
  assign in_ch.ready  = !in_valid_r || adv;

  // Effective terminator length, clamped to 1..DEPTH
  always_comb begin
    if (term_len_r == '0) begin
      len_clamp = TERM_LEN_W'(1);
    end else if (term_len_r > TERM_LEN_W'(DEPTH)) begin
      len_clamp = TERM_LEN_W'(DEPTH);
    end else begin
      len_clamp = term_len_r;
    end
  end
  assign len_eff = CNT_W'(len_clamp);
  assign len_m1  = len_eff - CNT_W'(1);

  // Terminator bytes in order, word 0 holding bytes 0 to 7
  assign term_flat  = term_word_r;
  assign term_bytes = term_flat[DEPTH*8-1:0];

  assign filling  = fill_r < len_eff;
  assign fill_inc = fill_r + CNT_W'(1);

  // Window candidates: fill at fill_r, or shift the active part left by one
  for (genvar i = 0; i < DEPTH; i++) begin : g_win
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    localparam logic [CNT_W-1:0] IP1 = CNT_W'(i + 1);
    assign win_fill[i] = (IDX == fill_r) ? in_byte_r : win_r[i];
    if (i < DEPTH - 1) begin : g_mid
      assign win_shift[i] = (IP1 < len_eff) ? win_r[i+1] :
                            (IDX == len_m1) ? in_byte_r : win_r[i];
    end else begin : g_last
      assign win_shift[i] = (IDX == len_m1) ? in_byte_r : win_r[i];
    end
  end

  assign win_nxt = filling ? win_fill : win_shift;
  assign full    = filling ? (fill_inc == len_eff) : 1'b1;

  sdd_match #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_match (
    .window (win_nxt),
    .term   (term_bytes),
    .len    (len_eff),
    .match  (match)
  );

  assign eom    = full && match;
  assign pc_inc = (&pc_r) ? pc_r : pc_r + LENGTH_BITS'(1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_len_r  <= TERM_LEN_W'(1);
      term_word_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TERM_LENGTH: term_len_r     <= cfg_data[TERM_LEN_W-1:0];
        REG_TERM_WORD_A: term_word_r[0] <= cfg_data;
        REG_TERM_WORD_B: term_word_r[1] <= cfg_data;
        REG_TERM_WORD_C: term_word_r[2] <= cfg_data;
        REG_TERM_WORD_D: term_word_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  // Window and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pc_r   <= '0;
    end else if (cfg_we && cfg_reg_t'(cfg_index) == REG_TERM_LENGTH) begin
      fill_r <= '0;
      pc_r   <= '0;
    end else if (proc) begin
      if (eom) begin
        fill_r <= '0;
        pc_r   <= '0;
      end else if (filling) begin
        fill_r <= fill_inc;
      end else begin
        pc_r <= pc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      win_r <= win_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= proc && (!filling || eom);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_byte_r <= filling ? '0 : win_r[0];
      out_has_r  <= !filling;
      out_eom_r  <= eom;
      out_len_r  <= (eom && !filling) ? pc_inc : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.payload_byte   = out_byte_r;
  assign out_ch.has_payload    = out_has_r;
  assign out_ch.end_of_message = out_eom_r;
  assign out_ch.message_length = out_len_r;

`ifndef SYNTHESIS
  // Fill count never runs past the active terminator length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_eff) else $error("fill count beyond terminator length");

  // No payload is counted while the window is still filling
  a_pc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != len_eff |-> pc_r == '0) else $error("payload count while filling");

  // A length only accompanies an end of message
  a_len_eom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_eom_r |-> out_len_r == '0)
    else $error("message length without end of message");

  // An empty message reports zero length
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eom_r && !out_has_r |-> out_len_r == '0)
    else $error("empty message with nonzero length");

  // A processed byte after fill always gives a result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !filling |=> out_valid_r) else $error("payload byte dropped");
`endif

endmodule

>>> hdl/sdd_match.sv
module sdd_match #(
  parameter int DEPTH = sdd_pkg::MAX_TERM_BYTES_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic [DEPTH-1:0][7:0] window,
  input  logic [DEPTH-1:0][7:0] term,
  input  logic [CNT_W-1:0]      len,
  output logic                  match
);
  import sdd_pkg::*;

  logic [DEPTH-1:0] byte_ok;

  // Per-byte compare; bytes at or beyond the active length always pass
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    assign byte_ok[i] = (IDX >= len) || (window[i] == term[i]);
  end

  assign match = &byte_ok;

endmodule
